// ===== design/http_chunked_body_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_defines
// Assertion macros shared by the chunked body decoder.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// check a property on every clock edge outside reset
`define HCBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helper functions of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    typedef logic [2:0]  t_phase;
    typedef logic [1:0]  t_subphase;
    typedef logic [1:0]  t_event;
    typedef logic [2:0]  t_err;
    typedef logic [3:0]  t_digits;

    localparam t_phase PH_SIZE  = 3'd0;
    localparam t_phase PH_DATA  = 3'd1;
    localparam t_phase PH_TCR   = 3'd2;
    localparam t_phase PH_TLF   = 3'd3;
    localparam t_phase PH_TRAIL = 3'd4;

    localparam t_subphase SP_LEAD   = 2'd0;
    localparam t_subphase SP_DIGITS = 2'd1;
    localparam t_subphase SP_TRAIL  = 2'd2;
    localparam t_subphase SP_EXT    = 2'd3;

    localparam t_event EV_DATA  = 2'd0;
    localparam t_event EV_END   = 2'd1;
    localparam t_event EV_ERROR = 2'd2;

    localparam t_err ERR_LINE_END   = 3'd0;
    localparam t_err ERR_LINE_LONG  = 3'd1;
    localparam t_err ERR_SIZE_LINE  = 3'd2;
    localparam t_err ERR_BODY_LARGE = 3'd3;
    localparam t_err ERR_CHUNK_TERM = 3'd4;

    localparam logic [0:0] CFG_MAX_BODY = 1'd0;
    localparam logic [0:0] CFG_MAX_LINE = 1'd1;

    localparam logic [31:0] MAX_BODY_RESET = 32'd8388608;
    localparam logic [15:0] MAX_LINE_RESET = 16'd8192;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam t_digits DIGITS_SAT = 4'd15;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

// ===== design/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips HTTP/1.1 chunked framing from a body stream, one byte per word.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       sink       i_valid / o_ready   i_data_byte
//  out      source     o_valid / i_ready   o_event_res, o_body_byte, o_error_code
//  cfg      sink       i_cfg_we            i_cfg_index, i_cfg_data
//
//  One word per cycle while results are taken; a word passes the input register,
//  and its result, if any, the result register. Each word is decoded in one pass
//  between the input and result registers. Synchronous active-low reset restores
//  limits and starts a new body. A stalled result holds the decoder; the input
//  register takes one more word, then the input stalls too.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder #(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_body_byte,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_out_valid;
    hcbd_pkg::t_event        r_out_event;
    logic [7:0]              r_out_byte;
    hcbd_pkg::t_err          r_out_code;
    logic [31:0]             r_max_body;
    logic [15:0]             r_max_line;

    hcbd_pkg::t_phase        r_phase,    n_phase;
    logic [15:0]             r_len,      n_len;
    logic                    r_cr,       n_cr;
    hcbd_pkg::t_subphase     r_sub,      n_sub;
    hcbd_pkg::t_digits       r_dc,       n_dc;
    logic                    r_inv,      n_inv;
    logic [31:0]             r_cc,       n_cc;
    logic [31:0]             r_total,    n_total;

    logic                    w_fire;
    logic                    res_valid;
    hcbd_pkg::t_event        res_event;
    logic [7:0]              res_byte;
    hcbd_pkg::t_err          res_code;
    logic [4:0]              w_hex;
    logic [31:0]             w_room;
    logic [31:0]             w_cc_shift;
    logic                    w_dc_full;

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    assign w_hex      = hcbd_pkg::hex_decode(r_in_byte);
    assign w_room     = r_max_body - r_total;
    assign w_cc_shift = (r_cc[31:28] != 4'd0) ? 32'hFFFF_FFFF : {r_cc[27:0], w_hex[3:0]};
    assign w_dc_full  = {1'b0, r_dc} >= 5'(MAX_SIZE_DIGITS);

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_cr      = r_cr;
        n_sub     = r_sub;
        n_dc      = r_dc;
        n_inv     = r_inv;
        n_cc      = r_cc;
        n_total   = r_total;
        res_valid = 1'b0;
        res_event = hcbd_pkg::EV_DATA;
        res_byte  = 8'd0;
        res_code  = hcbd_pkg::ERR_LINE_END;

        if (r_phase == hcbd_pkg::PH_DATA) begin
            res_valid = 1'b1;
            res_byte  = r_in_byte;
            n_total   = r_total + 32'd1;
            if (r_cc != 32'd0) n_cc = r_cc - 32'd1;
            if (n_cc == 32'd0) n_phase = hcbd_pkg::PH_TCR;
        end else if (r_phase == hcbd_pkg::PH_TCR) begin
            if (r_in_byte != hcbd_pkg::CH_CR) begin
                res_valid = 1'b1;
                res_event = hcbd_pkg::EV_ERROR;
                res_code  = hcbd_pkg::ERR_CHUNK_TERM;
            end else begin
                n_phase = hcbd_pkg::PH_TLF;
            end
        end else if (r_phase == hcbd_pkg::PH_TLF) begin
            if (r_in_byte != hcbd_pkg::CH_LF) begin
                res_valid = 1'b1;
                res_event = hcbd_pkg::EV_ERROR;
                res_code  = hcbd_pkg::ERR_CHUNK_TERM;
            end else begin
                n_len   = 16'd0;
                n_cr    = 1'b0;
                n_sub   = hcbd_pkg::SP_LEAD;
                n_dc    = '0;
                n_inv   = 1'b0;
                n_cc    = 32'd0;
                n_phase = hcbd_pkg::PH_SIZE;
            end
        end else begin
            if (r_phase != hcbd_pkg::PH_TRAIL) n_phase = hcbd_pkg::PH_SIZE;
            if (r_cr && r_in_byte != hcbd_pkg::CH_LF) begin
                res_valid = 1'b1;
                res_event = hcbd_pkg::EV_ERROR;
                res_code  = hcbd_pkg::ERR_LINE_END;
            end else if (r_in_byte == hcbd_pkg::CH_LF) begin
                // line end
                n_len = 16'd0;
                n_cr  = 1'b0;
                n_sub = hcbd_pkg::SP_LEAD;
                n_dc  = '0;
                n_inv = 1'b0;
                n_cc  = 32'd0;
                if (r_phase == hcbd_pkg::PH_TRAIL) begin
                    if (r_len == 16'd0) begin
                        res_valid = 1'b1;
                        res_event = hcbd_pkg::EV_END;
                    end
                end else if (r_inv || r_dc == '0) begin
                    res_valid = 1'b1;
                    res_event = hcbd_pkg::EV_ERROR;
                    res_code  = hcbd_pkg::ERR_SIZE_LINE;
                end else if (r_cc == 32'd0) begin
                    n_phase = hcbd_pkg::PH_TRAIL;
                end else if (r_total > r_max_body || r_cc > w_room) begin
                    res_valid = 1'b1;
                    res_event = hcbd_pkg::EV_ERROR;
                    res_code  = hcbd_pkg::ERR_BODY_LARGE;
                end else begin
                    n_cc    = r_cc;
                    n_phase = hcbd_pkg::PH_DATA;
                end
            end else if (r_in_byte == hcbd_pkg::CH_CR) begin
                n_cr = 1'b1;
            end else if (r_len >= r_max_line) begin
                res_valid = 1'b1;
                res_event = hcbd_pkg::EV_ERROR;
                res_code  = hcbd_pkg::ERR_LINE_LONG;
            end else begin
                n_len = r_len + 16'd1;
                if (n_phase == hcbd_pkg::PH_SIZE && r_sub != hcbd_pkg::SP_EXT) begin
                    if (r_in_byte == hcbd_pkg::CH_SEMI) begin
                        n_sub = hcbd_pkg::SP_EXT;
                    end else if (hcbd_pkg::is_blank(r_in_byte)) begin
                        if (r_sub == hcbd_pkg::SP_DIGITS) n_sub = hcbd_pkg::SP_TRAIL;
                    end else if (!w_hex[4] || r_sub == hcbd_pkg::SP_TRAIL) begin
                        n_inv = 1'b1;
                    end else begin
                        n_sub = hcbd_pkg::SP_DIGITS;
                        if (w_dc_full) begin
                            n_inv = 1'b1;
                        end else if (r_dc == hcbd_pkg::DIGITS_SAT) begin
                            n_cc = w_cc_shift;
                        end else begin
                            n_dc = r_dc + 4'd1;
                            n_cc = w_cc_shift;
                        end
                    end
                end
            end
        end

        // end of body or error: start over
        if (res_valid && res_event != hcbd_pkg::EV_DATA) begin
            n_phase = hcbd_pkg::PH_SIZE;
            n_len   = 16'd0;
            n_cr    = 1'b0;
            n_sub   = hcbd_pkg::SP_LEAD;
            n_dc    = '0;
            n_inv   = 1'b0;
            n_cc    = 32'd0;
            n_total = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_body  <= hcbd_pkg::MAX_BODY_RESET;
            r_max_line  <= hcbd_pkg::MAX_LINE_RESET;
            r_phase     <= hcbd_pkg::PH_SIZE;
            r_len       <= 16'd0;
            r_cr        <= 1'b0;
            r_sub       <= hcbd_pkg::SP_LEAD;
            r_dc        <= '0;
            r_inv       <= 1'b0;
            r_cc        <= 32'd0;
            r_total     <= 32'd0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (w_fire) begin
                r_out_valid <= res_valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_cr    <= n_cr;
                r_sub   <= n_sub;
                r_dc    <= n_dc;
                r_inv   <= n_inv;
                r_cc    <= n_cc;
                r_total <= n_total;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hcbd_pkg::CFG_MAX_BODY: r_max_body <= i_cfg_data;
                    hcbd_pkg::CFG_MAX_LINE: r_max_line <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_data_byte;
        if (w_fire) begin
            r_out_event <= res_event;
            r_out_byte  <= res_byte;
            r_out_code  <= res_code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_res  = r_out_event;
    assign o_body_byte  = r_out_byte;
    assign o_error_code = r_out_code;

    `HCBD_ASSERT(a_restart, (w_fire && res_valid && res_event != hcbd_pkg::EV_DATA) |=> (r_phase == hcbd_pkg::PH_SIZE && r_total == 32'd0), "body not restarted after end or error")
    `HCBD_ASSERT(a_count, (w_fire && r_phase == hcbd_pkg::PH_DATA) |=> (r_total == $past(r_total) + 32'd1), "body total not advanced on data word")
    `HCBD_ASSERT(a_data_left, (r_phase == hcbd_pkg::PH_DATA) |-> (r_cc != 32'd0), "data phase with no bytes left")
    `HCBD_ASSERT_ALWAYS(a_rst, (!i_rst_n) |=> (!o_valid && o_ready), "handshake not cleared by reset")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the chunked body decoder. Feeds chunked bodies one byte per
// word, predicts every data byte, body end and error in a behavioral decoder
// with its own copy of the limits, and compares each result word in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int               SIZE_DIGITS = 8;
    localparam hcbd_pkg::t_err   NO_ERROR    = '0;

    typedef struct packed {
        hcbd_pkg::t_event ev;
        logic [7:0]       data;
        hcbd_pkg::t_err   code;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_event_res;
    logic [7:0]  o_body_byte;
    logic [2:0]  o_error_code;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    http_chunked_body_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_res  (o_event_res),
        .o_body_byte  (o_body_byte),
        .o_error_code (o_error_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // decoder state and limits
    hcbd_pkg::t_phase    dec_phase;
    logic [15:0]         dec_line_len;
    logic                dec_saw_cr;
    hcbd_pkg::t_subphase dec_sub;
    hcbd_pkg::t_digits   dec_digits;
    logic                dec_bad_size;
    logic [31:0]         dec_count;
    logic [31:0]         dec_total;
    logic [31:0]         lim_body;
    logic [15:0]         lim_line;

    t_result expected_events[$];

    int  fail_count = 0;
    int  words_sent = 0;
    int  n_data = 0;
    int  n_ends = 0;
    int  n_errors = 0;
    bit  idling = 1'b1;
    bit  allow_idle = 1'b1;
    int  stall_left = 0;

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - 8'h30);
        if (c >= "a" && c <= "f") return int'(c - 8'h57);
        if (c >= "A" && c <= "F") return int'(c - 8'h37);
        return -1;
    endfunction

    function automatic void clear_line();
        dec_line_len = '0;
        dec_saw_cr   = 1'b0;
        dec_sub      = hcbd_pkg::SP_LEAD;
        dec_digits   = '0;
        dec_bad_size = 1'b0;
        dec_count    = '0;
    endfunction

    function automatic void clear_body();
        clear_line();
        dec_phase = hcbd_pkg::PH_SIZE;
        dec_total = '0;
    endfunction

    function automatic void post_event(input hcbd_pkg::t_event ev, input logic [7:0] b,
                                       input hcbd_pkg::t_err code);
        t_result r;
        r = '{ev, b, code};
        expected_events.insert(expected_events.size(), r);
    endfunction

    function automatic void fail_body(input hcbd_pkg::t_err code);
        post_event(hcbd_pkg::EV_ERROR, 8'h00, code);
        clear_body();
    endfunction

    function automatic void shift_digit(input int h);
        if (dec_count > 32'h0FFF_FFFF) dec_count = '1;
        else dec_count = {dec_count[27:0], 4'(h)};
    endfunction

    function automatic void size_char(input logic [7:0] c);
        int h;
        h = hex_val(c);
        if (dec_sub == hcbd_pkg::SP_EXT) return;
        if (c == hcbd_pkg::CH_SEMI) begin
            dec_sub = hcbd_pkg::SP_EXT;
            return;
        end
        if (c == hcbd_pkg::CH_SPACE || c == hcbd_pkg::CH_TAB) begin
            if (dec_sub == hcbd_pkg::SP_DIGITS) dec_sub = hcbd_pkg::SP_TRAIL;
            return;
        end
        if (h < 0 || dec_sub == hcbd_pkg::SP_TRAIL) begin
            dec_bad_size = 1'b1;
            return;
        end
        dec_sub = hcbd_pkg::SP_DIGITS;
        if (dec_digits >= SIZE_DIGITS || dec_digits >= hcbd_pkg::DIGITS_SAT) begin
            if (dec_digits >= SIZE_DIGITS) dec_bad_size = 1'b1;
            else shift_digit(h);
            if (!dec_bad_size && dec_digits < hcbd_pkg::DIGITS_SAT) dec_digits++;
            return;
        end
        dec_digits++;
        shift_digit(h);
    endfunction

    function automatic void close_line();
        logic [31:0] left;
        if (dec_phase == hcbd_pkg::PH_TRAIL) begin
            if (dec_line_len == 0) begin
                post_event(hcbd_pkg::EV_END, 8'h00, NO_ERROR);
                clear_body();
            end else begin
                clear_line();
            end
        end else if (dec_bad_size || dec_digits == 0) begin
            fail_body(hcbd_pkg::ERR_SIZE_LINE);
        end else if (dec_count == 0) begin
            clear_line();
            dec_phase = hcbd_pkg::PH_TRAIL;
        end else if (dec_total > lim_body || dec_count > lim_body - dec_total) begin
            fail_body(hcbd_pkg::ERR_BODY_LARGE);
        end else begin
            left = dec_count;
            clear_line();
            dec_count = left;
            dec_phase = hcbd_pkg::PH_DATA;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        if (dec_phase == hcbd_pkg::PH_DATA) begin
            post_event(hcbd_pkg::EV_DATA, c, NO_ERROR);
            dec_total++;
            if (dec_count != 0) dec_count--;
            if (dec_count == 0) dec_phase = hcbd_pkg::PH_TCR;
        end else if (dec_phase == hcbd_pkg::PH_TCR) begin
            if (c != hcbd_pkg::CH_CR) fail_body(hcbd_pkg::ERR_CHUNK_TERM);
            else dec_phase = hcbd_pkg::PH_TLF;
        end else if (dec_phase == hcbd_pkg::PH_TLF) begin
            if (c != hcbd_pkg::CH_LF) begin
                fail_body(hcbd_pkg::ERR_CHUNK_TERM);
            end else begin
                clear_line();
                dec_phase = hcbd_pkg::PH_SIZE;
            end
        end else begin
            if (dec_phase != hcbd_pkg::PH_TRAIL) dec_phase = hcbd_pkg::PH_SIZE;
            if (dec_saw_cr) begin
                if (c != hcbd_pkg::CH_LF) fail_body(hcbd_pkg::ERR_LINE_END);
                else close_line();
            end else if (c == hcbd_pkg::CH_LF) begin
                close_line();
            end else if (c == hcbd_pkg::CH_CR) begin
                dec_saw_cr = 1'b1;
            end else if (dec_line_len >= lim_line) begin
                fail_body(hcbd_pkg::ERR_LINE_LONG);
            end else begin
                dec_line_len++;
                if (dec_phase == hcbd_pkg::PH_SIZE) size_char(c);
            end
        end
    endfunction

    // track config, predict accepted words, check result words
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lim_body = hcbd_pkg::MAX_BODY_RESET;
            lim_line = hcbd_pkg::MAX_LINE_RESET;
            clear_body();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == hcbd_pkg::CFG_MAX_BODY) lim_body = i_cfg_data;
                else lim_line = i_cfg_data[15:0];
            end
            if (i_valid && o_ready) decode_byte(i_data_byte);
            if (o_valid && i_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result: event_res %0d body_byte %02h error_code %0d",
                           o_event_res, o_body_byte, o_error_code);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_res != want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, o_event_res);
                        fail_count++;
                    end
                    if (o_body_byte != want.data) begin
                        $error("body_byte: expected %02h, got %02h", want.data, o_body_byte);
                        fail_count++;
                    end
                    if (o_error_code != want.code) begin
                        $error("error_code: expected %0d, got %0d", want.code, o_error_code);
                        fail_count++;
                    end
                end
                case (o_event_res)
                    hcbd_pkg::EV_DATA: n_data++;
                    hcbd_pkg::EV_END:  n_ends++;
                    default: n_errors++;
                endcase
            end
        end
    end

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b);
        if (idling && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        words_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (hex_val(b) >= 0) b = "x";
        return b;
    endfunction

    function automatic string blanks();
        string s;
        s = "";
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) s = {s, " "};
            else s = {s, "\t"};
        end
        return s;
    endfunction

    function automatic string size_text(input logic [31:0] n);
        string digits;
        string s;
        digits = $sformatf("%0h", n);
        repeat ($urandom_range(0, 2)) begin
            if (digits.len() < SIZE_DIGITS) digits = {"0", digits};
        end
        for (int i = 0; i < digits.len(); i++) begin
            if (digits[i] >= "a" && $urandom_range(0, 1)) digits[i] = digits[i] - 8'h20;
        end
        s = {blanks(), digits, blanks()};
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) s = {s, ";ext=1"};
            else s = {s, "; q\tz"};
        end
        return s;
    endfunction

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    endfunction

    function automatic void push_eol(ref logic [7:0] q[$]);
        if ($urandom_range(0, 1)) q.insert(q.size(), hcbd_pkg::CH_CR);
        q.insert(q.size(), hcbd_pkg::CH_LF);
    endfunction

    // one well-formed body with random content, sometimes damaged
    task automatic send_body();
        logic [7:0]  body_q[$];
        logic [31:0] chunk_bytes;
        logic [7:0]  c;
        int          trail_len;
        for (int k = $urandom_range(0, 3); k > 0; k--) begin
            chunk_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                       : $urandom_range(1, 12);
            push_text(body_q, size_text(chunk_bytes));
            push_eol(body_q);
            repeat (chunk_bytes) body_q.insert(body_q.size(), 8'($urandom_range(0, 255)));
            body_q.insert(body_q.size(), hcbd_pkg::CH_CR);
            body_q.insert(body_q.size(), hcbd_pkg::CH_LF);
        end
        push_text(body_q, size_text(32'd0));
        push_eol(body_q);
        repeat ($urandom_range(0, 2)) begin
            trail_len = $urandom_range(1, 6);
            if ($urandom_range(0, 2) == 0) begin
                repeat (trail_len) begin
                    body_q.insert(body_q.size(), $urandom_range(0, 1) ? hcbd_pkg::CH_SPACE
                                                                      : hcbd_pkg::CH_TAB);
                end
            end else begin
                repeat (trail_len) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_LF) c = "x";
                    body_q.insert(body_q.size(), c);
                end
            end
            push_eol(body_q);
        end
        push_eol(body_q);
        if ($urandom_range(0, 7) == 0)
            body_q[$urandom_range(0, body_q.size() - 1)] = noise_byte();
        if ($urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 8)) body_q.insert(body_q.size(), noise_byte());
        idling = allow_idle && ($urandom_range(0, 3) != 0);
        foreach (body_q[i]) send_word(body_q[i]);
    endtask

    task automatic test_framing();
        send_text("2\r\n");
        send_word(8'h00);
        send_word(8'hFF);
        send_text("\r\n0\r\nX: y\r\n \t\r\n\r\n");
        send_text(" \tA \t;ext\n0123456789\r\n0\n\n");
        drain();
    endtask

    task automatic test_error_codes();
        send_text("1\rX");
        send_text("1 2\n\n");
        send_text("123456789\n");
        send_text("g\n");
        send_text("1\r\nAB");
        send_text("1\r\nA\rB");
        send_text("ffffffff\n");
        send_text("0\n\r\r");
        drain();
    endtask

    task automatic test_line_limits();
        write_reg(hcbd_pkg::CFG_MAX_LINE, 32'd0);
        send_text("1");
        write_reg(hcbd_pkg::CFG_MAX_LINE, 32'd1);
        send_text("1\nA\r\n10\n");
        write_reg(hcbd_pkg::CFG_MAX_LINE, 32'd3);
        send_text("0\nabcd\n");
        write_reg(hcbd_pkg::CFG_MAX_LINE, 32'h0000_FFFF);
        send_text("00000001\nZ\r\n0\n\n");
        write_reg(hcbd_pkg::CFG_MAX_LINE, {16'd0, hcbd_pkg::MAX_LINE_RESET});
    endtask

    task automatic test_body_limits();
        write_reg(hcbd_pkg::CFG_MAX_BODY, 32'd0);
        send_text("1\n0\n\n");
        write_reg(hcbd_pkg::CFG_MAX_BODY, 32'hFFFF_FFFF);
        send_text("1\nZ\r\nFFFFFFFF\n");
        write_reg(hcbd_pkg::CFG_MAX_BODY, 32'd3);
        send_text("2\nab\r\n1\nc\r\n1\n");
        write_reg(hcbd_pkg::CFG_MAX_BODY, 32'd5);
        send_text("3\nabc\r\n");
        // lower the limit below the bytes already passed
        write_reg(hcbd_pkg::CFG_MAX_BODY, 32'd2);
        send_text("1\n0\n\n");
        write_reg(hcbd_pkg::CFG_MAX_BODY, hcbd_pkg::MAX_BODY_RESET);
    endtask

    task automatic test_random_bodies(input int n_words, input logic [31:0] body_lim,
                                      input logic [15:0] line_lim);
        int target;
        write_reg(hcbd_pkg::CFG_MAX_BODY, body_lim);
        write_reg(hcbd_pkg::CFG_MAX_LINE, {16'd0, line_lim});
        target = words_sent + n_words;
        while (words_sent < target) send_body();
        drain();
    endtask

    task automatic test_full_rate();
        allow_idle = 1'b0;
        idling = 1'b0;
        test_random_bodies(100, hcbd_pkg::MAX_BODY_RESET, hcbd_pkg::MAX_LINE_RESET);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing();
        test_error_codes();
        test_line_limits();
        test_body_limits();
        test_random_bodies(160, hcbd_pkg::MAX_BODY_RESET, hcbd_pkg::MAX_LINE_RESET);
        test_random_bodies(130, 32'd24, 16'd5);
        test_random_bodies(90, 32'hFFFF_FFFF, 16'hFFFF);
        test_random_bodies(60, 32'd0, 16'd1);
        test_full_rate();
        drain();
        $display("%0d words sent under several limit settings", words_sent);
        $display("checked %0d data bytes, %0d body ends, %0d errors", n_data, n_ends, n_errors);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/hcbd_pkg.sv
design/http_chunked_body_decoder.sv
dv/tb.sv
